// ----- hw/rtl/silu_pkg.sv -----
`timescale 1ns / 1ps

package silu_pkg;

  localparam int XW = 16;
  localparam int DEF_EXP_TABLE_DEPTH = 64;
  localparam int DEF_FRAC_BITS = 12;

  localparam logic signed [XW-1:0] X_NEG_INF = 16'sh8000;
  localparam logic signed [XW-1:0] X_POS_MAX = 16'sh7fff;
  localparam logic signed [XW-1:0] RES_MAX = 16'sh7fff;
  localparam logic signed [XW-1:0] RES_MIN = 16'sh8000;

  typedef struct packed {
    logic                 req;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] up;
    logic                 ninf;
    logic                 pmax;
  } tag_t;

  // elaboration-time long division, shift and subtract
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= dvs) begin
        rem = rem - dvs;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-t_k) in unsigned Q31: series for t/256, then squared eight times
  function automatic logic [31:0] exp_entry(input int k, input int depth, input int fb);
    logic [63:0]        t;
    logic [63:0]        u;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] y;
    t = div_u64(64'(k) << (46 - fb), 64'(depth));
    u = t >> 8;
    y = 64'sh8000_0000;
    term = 64'h8000_0000;
    for (int n = 1; n <= 24; n++) begin
      term = div_u64((term * u) >> 31, 64'(n));
      if (n % 2 == 1) y = y - $signed(term);
      else y = y + $signed(term);
    end
    if (y < 0) y = '0;
    r = $unsigned(y);
    for (int n = 0; n < 8; n++) r = (r * r + 64'h4000_0000) >> 31;
    return r[31:0];
  endfunction

endpackage

// ----- hw/rtl/silu_forward_and_gradient.sv -----
`timescale 1ns / 1ps
// From input acceptance to out_valid a word passes stages s1-s4, the divider, p1-p7 and the output reg.
// Throughput: one word per cycle; the 32-stage restoring divider for the sigmoid
// sets the depth, every stage advances together unless the output skid is full.
// Reset: rst (sync, active high) clears every valid bit, output and skid included;
// the exp table is constant and needs no fill.
module silu_forward_and_gradient
  import silu_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = DEF_EXP_TABLE_DEPTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic signed [XW-1:0] x_value,
  input  logic signed [XW-1:0] upstream_grad,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [XW-1:0] result_value,
  output logic                 saturated
);

  localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PW = 15 + IW;
  localparam int NDIV = 32;

  logic [31:0] exp_tab [0:EXP_TABLE_DEPTH];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [31:0] EV = exp_entry(k, EXP_TABLE_DEPTH, FRAC_BITS);
    assign exp_tab[k] = EV;
  end

  logic en;
  logic skid_valid;
  assign en = !skid_valid;
  assign in_ready = en;

  // stage 1: |x| * depth
  logic          s1_valid;
  tag_t          s1_tag;
  logic [PW-1:0] s1_p;
  logic [XW-1:0] abs_x;
  assign abs_x = x_value[XW-1] ? XW'(-x_value) : x_value;

  // stage 2: table lookup
  logic          s2_valid;
  tag_t          s2_tag;
  logic [31:0]   s2_ei, s2_ei1;
  logic [14:0]   s2_f;
  logic [IW-1:0] idx0, idx1;
  assign idx0 = IW'(s1_p >> 15);
  assign idx1 = idx0 + 1'b1;

  // stage 3: interpolation products
  logic        s3_valid;
  tag_t        s3_tag;
  logic [47:0] s3_prod0, s3_prod1;

  // stage 4: e in Q31
  logic        s4_valid;
  tag_t        s4_tag;
  logic [31:0] s4_e;
  logic [48:0] e_sum;
  assign e_sum = {1'b0, s3_prod0} + {1'b0, s3_prod1};

  // divider: index 0 is the dividend/divisor stage
  logic        dv_valid [0:NDIV];
  tag_t        dv_tag   [0:NDIV];
  logic [32:0] dv_rem   [0:NDIV];
  logic [31:0] dv_lo    [0:NDIV];
  logic [31:0] dv_q     [0:NDIV];
  logic [32:0] dv_den   [0:NDIV];

  logic [63:0] div_num;
  logic [63:0] div_n;
  assign div_num = s4_tag.x[XW-1] ? {1'b0, s4_e, 31'b0} : 64'h4000_0000_0000_0000;
  // adds den/2 as 2^30 + (e >> 1), truncated when e is odd
  assign div_n = div_num + 64'h4000_0000 + 64'(s4_e >> 1);

  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    logic [33:0] trial;
    logic        ge;
    assign trial = {dv_rem[j-1], dv_lo[j-1][31]};
    assign ge = trial >= {1'b0, dv_den[j-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j] <= 1'b0;
      end else if (en) begin
        dv_valid[j] <= dv_valid[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_tag[j] <= dv_tag[j-1];
        dv_rem[j] <= ge ? 33'(trial - {1'b0, dv_den[j-1]}) : trial[32:0];
        dv_lo[j]  <= {dv_lo[j-1][30:0], 1'b0};
        dv_q[j]   <= {dv_q[j-1][30:0], ge};
        dv_den[j] <= dv_den[j-1];
      end
    end
  end

  // post-divide stages
  logic               p1_valid, p2_valid, p3_valid, p4_valid, p5_valid, p6_valid, p7_valid;
  tag_t               p1_tag, p2_tag, p3_tag, p4_tag, p5_tag, p6_tag;
  logic [31:0]        p1_s, p2_s, p3_s;
  logic signed [48:0] p1_fwd, p2_fwd, p3_fwd, p4_fwd, p5_fwd;
  logic [63:0]        p1_ss;
  logic [31:0]        p2_q;
  logic signed [47:0] p3_xq;
  logic signed [47:0] p4_d;
  logic signed [63:0] p5_ud;
  logic signed [33:0] p6_r;
  logic signed [XW-1:0] p7_res;
  logic               p7_sat;

  logic [31:0] s_q;
  assign s_q = dv_q[NDIV];

  logic [47:0]        xq_mag, rs_mag;
  logic signed [47:0] rs;
  assign xq_mag = p3_xq[47] ? 48'(-p3_xq) : p3_xq;
  assign rs_mag = (xq_mag + (48'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rs = p3_xq[47] ? -$signed(rs_mag) : $signed(rs_mag);

  logic signed [63:0] fin_v;
  logic [63:0]        fin_mag, fin_rnd;
  assign fin_v = p5_tag.req ? p5_ud : 64'(p5_fwd);
  assign fin_mag = fin_v[63] ? 64'(-fin_v) : fin_v;
  assign fin_rnd = (fin_mag + 64'h4000_0000) >> 31;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      dv_valid[0] <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      p5_valid <= 1'b0;
      p6_valid <= 1'b0;
      p7_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      dv_valid[0] <= s4_valid;
      p1_valid <= dv_valid[NDIV];
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      p5_valid <= p4_valid;
      p6_valid <= p5_valid;
      p7_valid <= p6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag.req  <= req_type;
      s1_tag.x    <= x_value;
      s1_tag.up   <= upstream_grad;
      s1_tag.ninf <= (x_value == X_NEG_INF);
      s1_tag.pmax <= (x_value == X_POS_MAX);
      s1_p        <= PW'(abs_x[14:0]) * PW'(EXP_TABLE_DEPTH);

      s2_tag <= s1_tag;
      s2_ei  <= exp_tab[idx0];
      s2_ei1 <= exp_tab[idx1];
      s2_f   <= s1_p[14:0];

      s3_tag   <= s2_tag;
      s3_prod0 <= 48'(s2_ei) * 48'(17'h08000 - {2'b0, s2_f});
      s3_prod1 <= 48'(s2_ei1) * 48'(s2_f);

      s4_tag <= s3_tag;
      s4_e   <= 32'(e_sum >> 15);

      dv_tag[0] <= s4_tag;
      dv_rem[0] <= 33'(div_n >> 32);
      dv_lo[0]  <= div_n[31:0];
      dv_q[0]   <= '0;
      dv_den[0] <= 33'h0_8000_0000 + {1'b0, s4_e};

      p1_tag <= dv_tag[NDIV];
      p1_s   <= s_q;
      p1_fwd <= 49'(dv_tag[NDIV].x) * $signed({17'b0, s_q});
      p1_ss  <= 64'(s_q) * 64'(32'h8000_0000 - s_q);

      p2_tag <= p1_tag;
      p2_s   <= p1_s;
      p2_fwd <= p1_fwd;
      p2_q   <= 32'((p1_ss + 64'h4000_0000) >> 31);

      p3_tag <= p2_tag;
      p3_s   <= p2_s;
      p3_fwd <= p2_fwd;
      p3_xq  <= 48'(p2_tag.x) * $signed({16'b0, p2_q});

      p4_tag <= p3_tag;
      p4_fwd <= p3_fwd;
      p4_d   <= $signed({16'b0, p3_s}) + rs;

      p5_tag <= p4_tag;
      p5_fwd <= p4_fwd;
      p5_ud  <= 64'(p4_tag.up) * 64'(p4_d);

      p6_tag <= p5_tag;
      p6_r   <= fin_v[63] ? -$signed(34'(fin_rnd)) : $signed(34'(fin_rnd));

      if (p6_tag.ninf) begin
        p7_res <= '0;
        p7_sat <= 1'b0;
      end else if (p6_tag.req && p6_tag.pmax) begin
        p7_res <= p6_tag.up;
        p7_sat <= 1'b0;
      end else if (p6_r > 34'(RES_MAX)) begin
        p7_res <= RES_MAX;
        p7_sat <= 1'b1;
      end else if (p6_r < 34'(RES_MIN)) begin
        p7_res <= RES_MIN;
        p7_sat <= 1'b1;
      end else begin
        p7_res <= p6_r[XW-1:0];
        p7_sat <= 1'b0;
      end
    end
  end

  // output register with one-word skid
  logic signed [XW-1:0] skid_res;
  logic                 skid_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= p7_valid;
      end
    end else if (p7_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        result_value <= skid_res;
        saturated    <= skid_sat;
      end else begin
        result_value <= p7_res;
        saturated    <= p7_sat;
      end
    end else if (!skid_valid) begin
      skid_res <= p7_res;
      skid_sat <= p7_sat;
    end
  end

endmodule
